// ===== rtl/core/fsne_pkg.sv =====
// ----------------------------------------------------------------------------
// fsne_pkg - shared types and constants of the format string number emitter
// Command record, state encoding, character codes and the hex digit table.
// ----------------------------------------------------------------------------
`default_nettype none

package fsne_pkg;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned DIGIT_DEPTH = 20;
  localparam int unsigned DIGIT_CNT_W = $clog2(DIGIT_DEPTH + 1);

  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_LOW_X  = 8'h78;
  localparam logic [7:0] CH_C      = 8'h43;
  localparam logic [7:0] CH_I      = 8'h49;
  localparam logic [7:0] CH_U      = 8'h55;
  localparam logic [7:0] CH_X      = 8'h58;
  localparam logic [7:0] CH_P      = 8'h50;
  localparam logic [7:0] CH_S      = 8'h53;
  localparam logic [7:0] CH_R      = 8'h52;

  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_INVALID = 2'd1;
  localparam logic [1:0] STATUS_UNSUP   = 2'd2;

  // ceil(2^35 / 10): exact quotient of a 32-bit value by ten after >> 35
  localparam logic [31:0] RECIP_TEN = 32'hCCCC_CCCD;

  typedef enum logic [1:0] {
    CMD_SINGLE,
    CMD_DEC,
    CMD_HEX
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic        neg;      // lead with a minus sign
    logic [7:0]  chr;      // character of a single result
    logic [1:0]  status;   // status of a single result
    logic [63:0] value;    // value to convert
  } cmd_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_CONV,
    BK_SIGN,
    BK_PRE0,
    BK_PREX,
    BK_EMIT,
    BK_SINGLE
  } back_state_t;

  function automatic logic [7:0] hex_char(input logic [3:0] digit);
    logic [7:0] c;
    case (digit)
      4'h0: c = 8'h30;
      4'h1: c = 8'h31;
      4'h2: c = 8'h32;
      4'h3: c = 8'h33;
      4'h4: c = 8'h34;
      4'h5: c = 8'h35;
      4'h6: c = 8'h36;
      4'h7: c = 8'h37;
      4'h8: c = 8'h38;
      4'h9: c = 8'h39;
      4'hA: c = 8'h41;
      4'hB: c = 8'h42;
      4'hC: c = 8'h43;
      4'hD: c = 8'h44;
      4'hE: c = 8'h45;
      default: c = 8'h46;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/fsne_front.sv =====
// ----------------------------------------------------------------------------
// fsne_front - format byte decoder
// Tracks the escape, decodes specifiers and pushes one command per result run.
// ----------------------------------------------------------------------------
`default_nettype none

module fsne_front (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [7:0]       format_char,
  input  wire logic [63:0]      argument,
  input  wire logic             q_full,
  output logic                  push,
  output fsne_pkg::cmd_t        push_cmd,
  output logic                  esc_pending
);

  logic        esc_r;
  logic        esc_nxt;
  logic        accept;
  logic [31:0] low_word;
  logic [31:0] low_neg;

  assign in_ready    = !q_full;
  assign accept      = in_valid && in_ready;
  assign esc_pending = esc_r;
  assign low_word    = argument[31:0];
  assign low_neg     = 32'd0 - low_word;

  // A dollar arms the escape and sends nothing down; everything else pushes.
  assign push = accept && !(!esc_r && (format_char == fsne_pkg::CH_DOLLAR));

  always_comb begin
    esc_nxt = esc_r;
    if (accept) begin
      esc_nxt = !esc_r && (format_char == fsne_pkg::CH_DOLLAR);
    end
  end

  always_comb begin
    push_cmd        = '0;
    push_cmd.kind   = fsne_pkg::CMD_SINGLE;
    push_cmd.status = fsne_pkg::STATUS_OK;
    if (!esc_r) begin
      push_cmd.chr = format_char;
    end else begin
      case (format_char)
        fsne_pkg::CH_C: begin
          push_cmd.chr = argument[7:0];
        end
        fsne_pkg::CH_I: begin
          push_cmd.kind  = fsne_pkg::CMD_DEC;
          push_cmd.neg   = low_word[31];
          push_cmd.value = {32'd0, (low_word[31] ? low_neg : low_word)};
        end
        fsne_pkg::CH_U: begin
          push_cmd.kind  = fsne_pkg::CMD_DEC;
          push_cmd.value = {32'd0, low_word};
        end
        fsne_pkg::CH_X: begin
          push_cmd.kind  = fsne_pkg::CMD_HEX;
          push_cmd.value = {32'd0, low_word};
        end
        fsne_pkg::CH_P: begin
          push_cmd.kind  = fsne_pkg::CMD_HEX;
          push_cmd.value = argument;
        end
        fsne_pkg::CH_S, fsne_pkg::CH_R: begin
          push_cmd.status = fsne_pkg::STATUS_UNSUP;
        end
        default: begin
          push_cmd.status = fsne_pkg::STATUS_INVALID;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      esc_r <= 1'b0;
    end else begin
      esc_r <= esc_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/fsne_queue.sv =====
// ----------------------------------------------------------------------------
// fsne_queue - command queue
// Small first-in first-out buffer between the decoder and the emitter.
// ----------------------------------------------------------------------------
`default_nettype none

module fsne_queue #(
  parameter int unsigned DEPTH = fsne_pkg::QUEUE_DEPTH   // 2 or more
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire fsne_pkg::cmd_t push_cmd,
  input  wire logic           pop,
  output logic                valid,
  output logic                full,
  output fsne_pkg::cmd_t      head
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  fsne_pkg::cmd_t   mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic [PTR_W-1:0] wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_nxt;
  logic [CNT_W-1:0] count_nxt;

  assign valid = (count_r != '0);
  assign full  = (count_r == CNT_W'(DEPTH));
  assign head  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/fsne_back.sv =====
// ----------------------------------------------------------------------------
// fsne_back - number conversion and character emitter
// Converts one digit a cycle into the digit store, then plays out the run.
// ----------------------------------------------------------------------------
`default_nettype none

module fsne_back (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           q_valid,
  input  wire fsne_pkg::cmd_t q_cmd,
  output logic                q_pop,
  output logic                out_valid,
  input  wire logic           out_ready,
  output logic [7:0]          out_char,
  output logic                out_last,
  output logic [1:0]          out_status
);

  localparam int unsigned CW = fsne_pkg::DIGIT_CNT_W;

  fsne_pkg::back_state_t state_r;
  fsne_pkg::back_state_t state_nxt;
  fsne_pkg::cmd_t        cmd_r;
  logic [63:0]           work_r;
  logic [CW-1:0]         cnt_r;
  logic [3:0]            store_r [fsne_pkg::DIGIT_DEPTH];

  logic                  out_valid_r;
  logic [7:0]            out_char_r;
  logic                  out_last_r;
  logic [1:0]            out_status_r;

  logic [63:0]           prod;
  logic [28:0]           quot;
  logic [31:0]           quot_x10;
  logic [31:0]           rem_full;
  logic [3:0]            digit;
  logic [63:0]           work_next;
  logic                  conv_done;
  logic                  emit_ok;
  logic                  emit;
  logic [7:0]            emit_char;
  logic                  emit_last;
  logic [1:0]            emit_status;
  logic [CW-1:0]         rd_idx;

  // Divide by ten through the reciprocal; remainder from q*8 + q*2.
  assign prod      = {32'd0, work_r[31:0]} * {32'd0, fsne_pkg::RECIP_TEN};
  assign quot      = prod[63:35];
  assign quot_x10  = {quot, 3'b000} + {2'b00, quot, 1'b0};
  assign rem_full  = work_r[31:0] - quot_x10;

  always_comb begin
    if (cmd_r.kind == fsne_pkg::CMD_HEX) begin
      digit     = work_r[3:0];
      work_next = {4'd0, work_r[63:4]};
    end else begin
      digit     = rem_full[3:0];
      work_next = {35'd0, quot};
    end
  end

  assign conv_done = (work_next == 64'd0) || (cnt_r == CW'(fsne_pkg::DIGIT_DEPTH - 1));
  assign emit_ok   = !out_valid_r || out_ready;
  assign rd_idx    = cnt_r - CW'(1);

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      fsne_pkg::BK_IDLE: begin
        if (q_valid) begin
          state_nxt = (q_cmd.kind == fsne_pkg::CMD_SINGLE) ? fsne_pkg::BK_SINGLE
                                                           : fsne_pkg::BK_CONV;
        end
      end
      fsne_pkg::BK_CONV: begin
        if (conv_done) begin
          if (cmd_r.neg) begin
            state_nxt = fsne_pkg::BK_SIGN;
          end else if (cmd_r.kind == fsne_pkg::CMD_HEX) begin
            state_nxt = fsne_pkg::BK_PRE0;
          end else begin
            state_nxt = fsne_pkg::BK_EMIT;
          end
        end
      end
      fsne_pkg::BK_SIGN: begin
        if (emit_ok) state_nxt = fsne_pkg::BK_EMIT;
      end
      fsne_pkg::BK_PRE0: begin
        if (emit_ok) state_nxt = fsne_pkg::BK_PREX;
      end
      fsne_pkg::BK_PREX: begin
        if (emit_ok) state_nxt = fsne_pkg::BK_EMIT;
      end
      fsne_pkg::BK_EMIT: begin
        if (emit_ok && (cnt_r == CW'(1))) state_nxt = fsne_pkg::BK_IDLE;
      end
      fsne_pkg::BK_SINGLE: begin
        if (emit_ok) state_nxt = fsne_pkg::BK_IDLE;
      end
      default: begin
        state_nxt = fsne_pkg::BK_IDLE;
      end
    endcase
  end

  // Outputs
  always_comb begin
    q_pop       = 1'b0;
    emit        = 1'b0;
    emit_char   = 8'd0;
    emit_last   = 1'b0;
    emit_status = fsne_pkg::STATUS_OK;
    case (state_r)
      fsne_pkg::BK_IDLE: begin
        q_pop = q_valid;
      end
      fsne_pkg::BK_SIGN: begin
        emit      = emit_ok;
        emit_char = fsne_pkg::CH_MINUS;
      end
      fsne_pkg::BK_PRE0: begin
        emit      = emit_ok;
        emit_char = fsne_pkg::CH_ZERO;
      end
      fsne_pkg::BK_PREX: begin
        emit      = emit_ok;
        emit_char = fsne_pkg::CH_LOW_X;
      end
      fsne_pkg::BK_EMIT: begin
        emit      = emit_ok;
        emit_char = fsne_pkg::hex_char(store_r[rd_idx]);
        emit_last = (cnt_r == CW'(1));
      end
      fsne_pkg::BK_SINGLE: begin
        emit        = emit_ok;
        emit_char   = cmd_r.chr;
        emit_last   = 1'b1;
        emit_status = cmd_r.status;
      end
      default: begin
        q_pop = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= fsne_pkg::BK_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (q_pop) begin
        cnt_r <= '0;
      end else if (state_r == fsne_pkg::BK_CONV) begin
        cnt_r <= cnt_r + CW'(1);
      end else if ((state_r == fsne_pkg::BK_EMIT) && emit_ok) begin
        cnt_r <= rd_idx;
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cmd_r  <= q_cmd;
      work_r <= q_cmd.value;
    end else if (state_r == fsne_pkg::BK_CONV) begin
      store_r[cnt_r] <= digit;
      work_r         <= work_next;
    end
    if (emit) begin
      out_char_r   <= emit_char;
      out_last_r   <= emit_last;
      out_status_r <= emit_status;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_char   = out_char_r;
  assign out_last   = out_last_r;
  assign out_status = out_status_r;

endmodule

`default_nettype wire

// ===== rtl/core/format_string_number_emitter.sv =====
// ----------------------------------------------------------------------------
// format_string_number_emitter - printf-style integer formatter
// Streams format bytes with argument words and streams out characters.
// ----------------------------------------------------------------------------
// Each input word carries one format byte and a 64-bit argument. A plain byte
// comes back as one character; '$' arms an escape and produces nothing; the
// byte after '$' picks a specifier: C (low byte), I (signed 32-bit decimal,
// '-' first when negative, the most negative value printed as 2147483648),
// U (unsigned 32-bit decimal), X ("0x" and upper-case hex of the low 32 bits)
// and P ("0x" and hex of all 64 bits). S and R return one word with status 2,
// any other specifier one word with status 1; both carry character zero. The
// last word of each run has tlast set. A decoder front end accepts a word a
// cycle, while the queue is not full, into a two-deep command queue; the
// emitter behind it converts one digit per cycle (a reciprocal multiply for
// base ten, a nibble shift for hex) and then plays out one character per
// cycle while the output is taken. A plain byte passes through the idle and
// single states; a number through idle, the conversion loop, any prefix
// ('-' or "0x") and the digit play-out, paced by the single output register.
// ----------------------------------------------------------------------------
`default_nettype none

module format_string_number_emitter #(
  parameter int unsigned QUEUE_DEPTH = fsne_pkg::QUEUE_DEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // format input
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [71:0] in_tdata,   // [7:0] format_char, [71:8] argument
  // character output
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [7:0]       out_tdata,  // [7:0] out_char
  output logic             out_tlast,
  output logic [1:0]       out_tuser   // [1:0] status
);

  logic           q_full;
  logic           q_valid;
  logic           push;
  logic           pop;
  logic           esc_pending;
  fsne_pkg::cmd_t push_cmd;
  fsne_pkg::cmd_t head_cmd;

  // Decode format bytes; hold the escape between words.
  fsne_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .format_char (in_tdata[7:0]),
    .argument    (in_tdata[71:8]),
    .q_full      (q_full),
    .push        (push),
    .push_cmd    (push_cmd),
    .esc_pending (esc_pending)
  );

  // Decouple decoding from the multi-cycle emitter.
  fsne_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .valid    (q_valid),
    .full     (q_full),
    .head     (head_cmd)
  );

  // Convert and play out one command at a time.
  fsne_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_cmd      (head_cmd),
    .q_pop      (pop),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_char   (out_tdata),
    .out_last   (out_tlast),
    .out_status (out_tuser)
  );

`ifndef SYNTHESIS
  // A dollar byte that arms the escape never queues a command.
  a_dollar_no_push: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && !esc_pending && (in_tdata[7:0] == fsne_pkg::CH_DOLLAR))
      |-> !push)
    else $error("dollar byte pushed a command");

  // An error word is a run of its own with a zero character.
  a_error_single: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tuser != fsne_pkg::STATUS_OK)) |-> (out_tlast && (out_tdata == 8'd0)))
    else $error("error result is not a lone zero character");

  // The queue is never pushed while full.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_full |-> !push)
    else $error("command queue overflow");
`endif

endmodule

`default_nettype wire
